[rtl/lswc_pkg.sv]
// ----------------------------------------------------------------------------
// lswc_pkg: shared types and constants of the line segment window clipper
// Outcode bits, outcode type and the pass limit.
// ----------------------------------------------------------------------------
package lswc_pkg;

    localparam int unsigned MAX_CLIP_PASSES = 4;

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    typedef logic [3:0] t_outcode;

endpackage

[rtl/lswc_div_cell.sv]
// ----------------------------------------------------------------------------
// lswc_div_cell: one restoring-division cell
// Takes a partial remainder and one numerator bit, gives the next remainder
// and one quotient bit. Cells chain into a row; each hands its remainder on.
// ----------------------------------------------------------------------------
module lswc_div_cell #(
    parameter int unsigned W = 17
) (
    input  logic [W-1:0] i_rem,
    input  logic         i_bit,
    input  logic [W-1:0] i_div,
    output logic [W-1:0] o_rem,
    output logic         o_q
);
    logic [W:0] w_sh;
    logic [W:0] w_diff;

    assign w_sh   = {i_rem, i_bit};
    assign w_diff = w_sh - {1'b0, i_div};
    assign o_q    = (w_sh >= {1'b0, i_div});
    assign o_rem  = o_q ? w_diff[W-1:0] : w_sh[W-1:0];
endmodule

[rtl/lswc_divider.sv]
// ----------------------------------------------------------------------------
// lswc_divider: unsigned divider built as a row of division cells
// A quotient of NW bits is formed CELLS bits per cycle by a row of CELLS
// cells; the last cell's remainder goes back to the first cell each cycle.
// ----------------------------------------------------------------------------
module lswc_divider #(
    parameter int unsigned NW    = 34,
    parameter int unsigned DW    = 17,
    parameter int unsigned CELLS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned ROUNDS = (NW + CELLS - 1) / CELLS;
    localparam int unsigned PW     = ROUNDS * CELLS;
    localparam int unsigned RW     = $clog2(ROUNDS + 1);

    logic [PW-1:0] r_num;
    logic [PW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [RW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW-1:0]    w_rem [CELLS+1];
    logic [CELLS-1:0] w_q;

    assign w_rem[0] = r_rem;

    // cell 0 takes the most significant pending numerator bit
    genvar k;
    generate
        for (k = 0; k < CELLS; k++) begin : g_cell
            lswc_div_cell #(.W(DW)) u_cell (
                .i_rem (w_rem[k]),
                .i_bit (r_num[PW-1-k]),
                .i_div (r_den),
                .o_rem (w_rem[k+1]),
                .o_q   (w_q[CELLS-1-k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= PW'(i_num);
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[PW-CELLS-1:0], w_q};
                r_num <= r_num << CELLS;
                r_rem <= w_rem[CELLS];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RW'(ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[NW-1:0];
endmodule

[rtl/line_segment_window_clipper.sv]
// ----------------------------------------------------------------------------
// line_segment_window_clipper: Cohen-Sutherland clip of one segment
// Clips a segment against the configured window and reports whether it hit.
// ----------------------------------------------------------------------------
// One segment at a time. A trivially accepted or rejected segment needs no
// endpoint move. Each endpoint move (at most four) runs a test step, a multiply
// step, a start step, an unsigned division of a 2W+2 bit product by a W+1 bit
// delta formed two quotient bits per cycle, and a step to take the quotient.
// The result sits in an output register; the next segment is taken once that
// register has been read.
module line_segment_window_clipper #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, accepted
    output logic [((4*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]   i_cfg_data
);
    import lswc_pkg::*;

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned DW  = W + 1;
    localparam int unsigned NW  = 2 * W + 2;
    localparam int unsigned OTW = ((4*W+8)/8)*8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TEST = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] CFG_XMIN = 2'd0;
    localparam logic [1:0] CFG_YMIN = 2'd1;
    localparam logic [1:0] CFG_XMAX = 2'd2;
    localparam logic [1:0] CFG_YMAX = 2'd3;

    logic signed [W-1:0] r_xl, r_yl, r_xh, r_yh;
    logic signed [W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [W-1:0] r_nx, r_ny;       // fixed coordinate on the edge
    logic signed [DW-1:0] r_a, r_b, r_d;   // signed deltas; the move is a*b/d
    logic [NW-1:0]       r_prod;
    logic                r_neg;
    logic                r_move_start;
    logic                r_vert;           // top/bottom edge: new x computed
    logic [2:0]          r_state;
    logic [2:0]          r_pass;
    logic                r_ovalid;
    logic [OTW-1:0]      r_odata;
    logic                r_div_start;

    t_outcode w_c0, w_c1, w_c;
    logic signed [DW-1:0] w_dx, w_dy;
    logic                 w_div_done;
    logic [NW-1:0]        w_quo;
    logic signed [DW-1:0] w_q;
    logic signed [W-1:0]  w_base, w_newv;

    function automatic t_outcode f_oc(input logic signed [W-1:0] x, y,
                                      xl, yl, xh, yh);
        t_outcode c;
        c = '0;
        if (y > yh) c = c | OC_TOP;
        if (y < yl) c = c | OC_BOTTOM;
        if (x < xl) c = c | OC_LEFT;
        if (x > xh) c = c | OC_RIGHT;
        return c;
    endfunction

    assign w_c0 = f_oc(r_sx, r_sy, r_xl, r_yl, r_xh, r_yh);
    assign w_c1 = f_oc(r_ex, r_ey, r_xl, r_yl, r_xh, r_yh);
    assign w_c  = (w_c0 != '0) ? w_c0 : w_c1;
    assign w_dx = DW'(r_ex) - DW'(r_sx);
    assign w_dy = DW'(r_ey) - DW'(r_sy);

    lswc_divider #(.NW(NW), .DW(DW), .CELLS(2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod),
        .i_den   (r_d[DW-1] ? DW'(-r_d) : r_d),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // quotient magnitude fits W+1 bits since |b| <= |d|
    assign w_q    = r_neg ? DW'(-w_quo[DW-1:0]) : w_quo[DW-1:0];
    assign w_base = r_vert ? r_sx : r_sy;
    assign w_newv = W'(DW'(w_base) + w_q);

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xl        <= '0;
            r_yl        <= '0;
            r_xh        <= W'(639);
            r_yh        <= W'(479);
            r_state     <= ST_IDLE;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_pass      <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_XMIN: r_xl <= i_cfg_data;
                    CFG_YMIN: r_yl <= i_cfg_data;
                    CFG_XMAX: r_xh <= i_cfg_data;
                    CFG_YMAX: r_yh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_sx    <= s_axis_tdata[W-1:0];
                        r_sy    <= s_axis_tdata[2*W-1:W];
                        r_ex    <= s_axis_tdata[3*W-1:2*W];
                        r_ey    <= s_axis_tdata[4*W-1:3*W];
                        r_pass  <= '0;
                        r_state <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    r_move_start <= (w_c0 != '0);
                    if (w_c0 == '0 && w_c1 == '0) begin
                        r_odata  <= OTW'({1'b1, r_ey, r_ex, r_sy, r_sx});
                        r_state  <= ST_OUT;
                    end else if ((w_c0 & w_c1) != '0 ||
                                 r_pass == 3'(MAX_CLIP_PASSES)) begin
                        r_odata <= '0;
                        r_state <= ST_OUT;
                    end else if ((w_c & (OC_TOP | OC_BOTTOM)) != '0) begin
                        r_vert  <= 1'b1;
                        r_ny    <= ((w_c & OC_TOP) != '0) ? r_yh : r_yl;
                        r_a     <= w_dx;
                        r_b     <= DW'((((w_c & OC_TOP) != '0) ? r_yh : r_yl))
                                   - DW'(r_sy);
                        r_d     <= w_dy;
                        if (w_dy == '0) begin
                            r_odata <= '0;
                            r_state <= ST_OUT;
                        end else r_state <= ST_MUL;
                    end else begin
                        r_vert  <= 1'b0;
                        r_nx    <= ((w_c & OC_LEFT) != '0) ? r_xl : r_xh;
                        r_a     <= w_dy;
                        r_b     <= DW'((((w_c & OC_LEFT) != '0) ? r_xl : r_xh))
                                   - DW'(r_sx);
                        r_d     <= w_dx;
                        if (w_dx == '0) begin
                            r_odata <= '0;
                            r_state <= ST_OUT;
                        end else r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod <= NW'((r_a[DW-1] ? DW'(-r_a) : r_a))
                            * NW'((r_b[DW-1] ? DW'(-r_b) : r_b));
                    r_neg  <= (r_a[DW-1] ^ r_b[DW-1] ^ r_d[DW-1])
                              && r_a != '0 && r_b != '0;
                    r_div_start <= 1'b1;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_pass <= r_pass + 3'd1;
                        if (r_move_start) begin
                            r_sx <= r_vert ? w_newv : r_nx;
                            r_sy <= r_vert ? r_ny : w_newv;
                        end else begin
                            r_ex <= r_vert ? w_newv : r_nx;
                            r_ey <= r_vert ? r_ny : w_newv;
                        end
                        r_state <= ST_TEST;
                    end
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

[rtl/lswc_checker.sv]
// ----------------------------------------------------------------------------
// lswc_checker: port-level checks of the clipper
// Watches the stream ports over time.
// ----------------------------------------------------------------------------
module lswc_checker #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((4*COORD_WIDTH+8)/8)*8-1:0]   m_axis_tdata
);
    localparam int unsigned AB = 4 * COORD_WIDTH;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[AB] |-> m_axis_tdata[AB-1:0] == '0)
        else $error("rejected result carries coordinates");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("transfer overlap");
endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
